[src/assert_macros.svh]
// assertion helpers included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge forces consequent at the next
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/i2d_pkg.sv]
package i2d_pkg;

  localparam int WORD_W    = 64;
  localparam int DIGIT_CNT = 20;
  localparam int BCD_W     = 4 * DIGIT_CNT;
  localparam int CHAR_W    = 7;
  localparam int CNT_W     = $clog2(WORD_W);
  localparam int REM_W     = $clog2(DIGIT_CNT + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BCD_W-1:0]  bcd_t;
  typedef logic [CHAR_W-1:0] char_t;

  // double dabble unit status
  typedef struct packed {
    logic busy;
    logic done;
  } dab_stat_t;

  // hand-off from converter to character emitter
  typedef struct packed {
    logic load;
    logic neg;
  } emit_ctl_t;

endpackage

[src/i2d_if.sv]
interface i2d_in_if;
  import i2d_pkg::*;

  logic  valid;
  logic  ready;
  logic  command;
  word_t value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface i2d_out_if;
  import i2d_pkg::*;

  logic  valid;
  logic  ready;
  char_t out_char;
  logic  last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink (input valid, input out_char, input last, output ready);
endinterface

[src/i2d_dabble.sv]
module i2d_dabble (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  i2d_pkg::word_t    mag,
  output i2d_pkg::dab_stat_t stat,
  output i2d_pkg::bcd_t     bcd
);
  import i2d_pkg::*;

  word_t            sh;
  bcd_t             acc;
  bcd_t             acc_adj;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < DIGIT_CNT; d++) begin
      if (acc[4*d +: 4] >= 4'd5) begin
        acc_adj[4*d +: 4] = acc[4*d +: 4] + 4'd3;
      end else begin
        acc_adj[4*d +: 4] = acc[4*d +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        sh   <= mag;
        acc  <= '0;
      end else if (busy) begin
        sh  <= {sh[WORD_W-2:0], 1'b0};
        acc <= {acc_adj[BCD_W-2:0], sh[WORD_W-1]};
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign bcd       = acc;

endmodule

[src/i2d_emit.sv]
module i2d_emit (
  input  logic               clk,
  input  logic               rst,
  input  i2d_pkg::emit_ctl_t ctl,
  input  i2d_pkg::bcd_t      bcd,
  output logic               busy,
  i2d_out_if.source          chars
);
  import i2d_pkg::*;

  bcd_t             digs;
  logic [REM_W-1:0] rem;
  logic             active;
  logic             sign_pend;
  logic             started;
  logic             out_valid;
  char_t            out_char;
  logic             last;
  logic             take;
  logic             fire;
  logic [3:0]       top;

  assign top  = digs[BCD_W-1 -: 4];
  // output register is free or being emptied this cycle
  assign take = !out_valid || chars.ready;
  // a sign or a digit goes into the output register this cycle
  assign fire = active && !ctl.load && take
                && (sign_pend || started || top != 4'd0 || rem <= REM_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      sign_pend <= 1'b0;
      started   <= 1'b0;
      rem       <= '0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (chars.ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.load) begin
        active    <= 1'b1;
        sign_pend <= ctl.neg;
        started   <= 1'b0;
        rem       <= REM_W'(DIGIT_CNT);
        digs      <= bcd;
      end else if (active) begin
        if (sign_pend) begin
          if (take) begin
            out_char  <= ASCII_MINUS;
            last      <= 1'b0;
            sign_pend <= 1'b0;
          end
        end else if (!started && top == 4'd0 && rem > REM_W'(1)) begin
          // drop a leading zero without a beat
          digs <= {digs[BCD_W-5:0], 4'd0};
          rem  <= rem - REM_W'(1);
        end else if (take) begin
          out_char  <= ASCII_ZERO + {3'd0, top};
          last      <= (rem == REM_W'(1));
          digs      <= {digs[BCD_W-5:0], 4'd0};
          rem       <= rem - REM_W'(1);
          started   <= 1'b1;
          if (rem == REM_W'(1)) begin
            active <= 1'b0;
          end
        end
      end
    end
  end

  assign busy           = active || out_valid;
  assign chars.valid    = out_valid;
  assign chars.out_char = out_char;
  assign chars.last     = last;

endmodule

[src/integer_to_decimal_ascii_unit.sv]
// Formats one 64-bit word per beat as decimal ASCII, one character per output
// beat, most significant digit first with no leading zeros and last set on the
// final character. With command set the word is two's complement and a
// negative value gives a leading '-' and its magnitude, the most negative
// value included. One number is in flight at a time: the bit-serial double
// dabble runs over all 64 bits, then the emitter puts out a sign when
// negative and walks all 20 digit positions at one per cycle (skipping
// leading zeros or emitting) while the output side does not stall.
`include "assert_macros.svh"

module integer_to_decimal_ascii_unit (
  input  logic     clk,
  input  logic     rst,
  i2d_in_if.sink   number,
  i2d_out_if.source chars
);
  import i2d_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       neg;
  logic       accept;
  logic       in_neg;
  word_t      mag;
  dab_stat_t  dab_stat;
  bcd_t       bcd;
  emit_ctl_t  emit_ctl;
  logic       emit_busy;

  assign number.ready = (state == S_IDLE);
  assign accept       = number.valid && number.ready;
  assign in_neg       = number.command && number.value[WORD_W-1];
  assign mag          = in_neg ? (~number.value + word_t'(1)) : number.value;

  assign emit_ctl.load = dab_stat.done;
  assign emit_ctl.neg  = neg;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_CONV;
      end
      S_CONV: begin
        if (dab_stat.done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!emit_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    if (accept) begin
      neg <= in_neg;
    end
  end

  i2d_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .mag   (mag),
    .stat  (dab_stat),
    .bcd   (bcd)
  );

  i2d_emit u_emit (
    .clk   (clk),
    .rst   (rst),
    .ctl   (emit_ctl),
    .bcd   (bcd),
    .busy  (emit_busy),
    .chars (chars)
  );

  `ASSERT_NEXT(a_start_conv, clk, rst, accept, dab_stat.busy, "conversion did not start")
  `ASSERT_ALWAYS(a_done_in_conv, clk, rst, !dab_stat.done || state == S_CONV, "stray done")
  `ASSERT_ALWAYS(a_accept_idle, clk, rst, !accept || (!emit_busy && !dab_stat.busy), "accept while busy")
  `ASSERT_NEXT(a_last_frees, clk, rst, chars.valid && chars.ready && chars.last, !emit_busy, "emitter busy after last")

endmodule

[tb/sv/integer_to_decimal_ascii_unit_tb.sv]
module integer_to_decimal_ascii_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2d_pkg::*;

  localparam logic CMD_UNSIGNED = 1'b0;
  localparam logic CMD_SIGNED   = 1'b1;
  localparam int   DEC_BASE     = 10;
  localparam int   STALL_LIMIT  = 5000;
  localparam int   DRAIN_CYCLES = 120;
  localparam int   RAND_PER_PHASE = 114;

  typedef struct {
    logic  cmd;
    word_t val;
    int    phase;
    bit    hold;
  } number_item_t;

  typedef struct {
    char_t ch;
    logic  last;
  } char_beat_t;

  logic clk;
  logic rst;

  i2d_in_if  number_if ();
  i2d_out_if chars_if ();

  integer_to_decimal_ascii_unit dut (
    .clk    (clk),
    .rst    (rst),
    .number (number_if),
    .chars  (chars_if)
  );

  number_item_t pending_numbers[$];
  char_beat_t   expected_chars[$];
  char_beat_t   oldest_char;
  int           mismatches;
  int           stall_cycles;
  int           rx_phase;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int tx_idle_pct(int phase);
    case (phase)
      0:       return 12;
      1:       return 88;
      default: return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct(int phase);
    case (phase)
      0:       return 88;
      1:       return 12;
      default: return 0;
    endcase
  endfunction

  // decimal digits of the magnitude, optional leading minus
  function automatic void predict_chars(input logic cmd, input word_t raw);
    word_t mag;
    logic  neg;
    char_t digits[$];
    char_beat_t beat;
    neg = (cmd == CMD_SIGNED) && raw[WORD_W-1];
    mag = neg ? (word_t'(0) - raw) : raw;
    if (neg) begin
      beat.ch   = ASCII_MINUS;
      beat.last = 1'b0;
      expected_chars.push_back(beat);
    end
    do begin
      digits.push_front(ASCII_ZERO + char_t'(mag % DEC_BASE));
      mag = mag / DEC_BASE;
    end while (mag != 0);
    for (int i = 0; i < digits.size(); i++) begin
      beat.ch   = digits[i];
      beat.last = (i == digits.size() - 1);
      expected_chars.push_back(beat);
    end
  endfunction

  function automatic void add_number(logic cmd, word_t val, int phase, bit hold);
    number_item_t item;
    item.cmd   = cmd;
    item.val   = val;
    item.phase = phase;
    item.hold  = hold;
    pending_numbers.push_back(item);
  endfunction

  function automatic word_t random_value();
    word_t v;
    word_t p10;
    int    k;
    case ($urandom_range(5))
      0: v = {$urandom, $urandom};
      1: v = word_t'($urandom_range(1000));
      2: begin
        // neighbors of a power of ten, wrapping around zero on purpose
        k = $urandom_range(19);
        p10 = 1;
        repeat (k) p10 = p10 * DEC_BASE;
        v = p10 + word_t'($urandom_range(4)) - word_t'(2);
      end
      3: v = word_t'(0) - word_t'($urandom_range(1, 1000));
      4: v = {$urandom, $urandom} >> $urandom_range(63);
      default: v = {1'b1, 63'(0)} + word_t'($urandom_range(3)) - word_t'(1);
    endcase
    return v;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      number_if.valid   <= 1'b0;
      number_if.command <= CMD_UNSIGNED;
      number_if.value   <= '0;
    end else begin
      if (number_if.valid && number_if.ready) begin
        predict_chars(number_if.command, number_if.value);
      end
      if (!number_if.valid || number_if.ready) begin
        if (pending_numbers.size() > 0
            && !(pending_numbers[0].hold
                 && (expected_chars.size() != 0 || number_if.valid))
            && $urandom_range(99) >= tx_idle_pct(pending_numbers[0].phase)) begin
          number_if.valid   <= 1'b1;
          number_if.command <= pending_numbers[0].cmd;
          number_if.value   <= pending_numbers[0].val;
          rx_phase          <= pending_numbers[0].phase;
          void'(pending_numbers.pop_front());
        end else begin
          number_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      chars_if.ready <= 1'b0;
    end else begin
      chars_if.ready <= ($urandom_range(99) >= rx_idle_pct(rx_phase));
      if (chars_if.valid && chars_if.ready) begin
        if (expected_chars.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat, expected none, actual char %h last %b",
                   $time, chars_if.out_char, chars_if.last);
        end else begin
          oldest_char = expected_chars.pop_front();
          if (chars_if.out_char !== oldest_char.ch) begin
            mismatches++;
            $display("%0t: out_char mismatch, expected %h actual %h",
                     $time, oldest_char.ch, chars_if.out_char);
          end
          if (chars_if.last !== oldest_char.last) begin
            mismatches++;
            $display("%0t: last mismatch, expected %b actual %b",
                     $time, oldest_char.last, chars_if.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (number_if.valid && number_if.ready) || (chars_if.valid && chars_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("integer_to_decimal_ascii_unit_tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    mismatches        = 0;
    stall_cycles      = 0;
    rx_phase          = 0;
    rst               = 1'b1;
    number_if.valid   = 1'b0;
    number_if.command = CMD_UNSIGNED;
    number_if.value   = '0;
    chars_if.ready    = 1'b0;

    // zero both ways, single digits, digit-count boundaries, sign edges
    add_number(CMD_UNSIGNED, 64'd0, 0, 1'b0);
    add_number(CMD_SIGNED, 64'd0, 0, 1'b0);
    add_number(CMD_UNSIGNED, 64'd1, 0, 1'b0);
    add_number(CMD_SIGNED, 64'd1, 0, 1'b0);
    add_number(CMD_UNSIGNED, 64'd9, 0, 1'b0);
    add_number(CMD_UNSIGNED, 64'd10, 0, 1'b0);
    add_number(CMD_SIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
    add_number(CMD_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
    add_number(CMD_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFE, 0, 1'b0);
    add_number(CMD_SIGNED, 64'h8000_0000_0000_0000, 0, 1'b0);
    add_number(CMD_UNSIGNED, 64'h8000_0000_0000_0000, 0, 1'b0);
    add_number(CMD_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF, 0, 1'b0);
    add_number(CMD_UNSIGNED, 64'h7FFF_FFFF_FFFF_FFFF, 0, 1'b0);
    add_number(CMD_SIGNED, 64'h8000_0000_0000_0001, 0, 1'b0);
    add_number(CMD_SIGNED, 64'hFFFF_FFFF_FFFF_FFF7, 0, 1'b0);
    add_number(CMD_SIGNED, 64'hFFFF_FFFF_FFFF_FFF6, 0, 1'b0);
    add_number(CMD_UNSIGNED, 64'd9999999999999999999, 0, 1'b0);
    add_number(CMD_UNSIGNED, 64'd10000000000000000000, 0, 1'b0);
    add_number(CMD_UNSIGNED, 64'd999999, 0, 1'b0);
    add_number(CMD_SIGNED, word_t'(0) - word_t'(1000000), 0, 1'b0);
    add_number(CMD_UNSIGNED, 64'h5555_5555_5555_5555, 0, 1'b0);
    add_number(CMD_SIGNED, 64'hAAAA_AAAA_AAAA_AAAA, 0, 1'b0);

    // first number of each later phase waits for the block to drain
    for (int phase = 0; phase < 3; phase++) begin
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        add_number(logic'($urandom_range(1)), random_value(), phase,
                   (phase != 0) && (n == 0));
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_numbers.size() != 0 || number_if.valid || expected_chars.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("integer_to_decimal_ascii_unit_tb OK");
    end else begin
      $display("integer_to_decimal_ascii_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
